>>> src/es2u_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the epoch seconds to UTC date converter.
// Used by es2u_ctrl and epoch_seconds_to_utc_date; depends on nothing else.
package es2u_pkg;

    // Number of register stages in the datapath, the output register included.
    localparam int NSTAGE = 6;

    // Hold and valid bits of every stage, handed from the control unit to the datapath.
    typedef struct packed {
        logic [NSTAGE-1:0] load;
        logic [NSTAGE-1:0] valid;
    } t_pipe_ctl;

    // Reciprocals for the constant divisions. Each one rounds down, so the
    // quotient it gives is exact or one too small, and a single compare and
    // subtract puts it right.
    localparam logic [25:0] DAY_RECIP   = 26'd50903316; // 2^35 / 675, for seconds >> 7
    localparam logic [12:0] HOUR_RECIP  = 13'd4660;     // 2^20 / 225, for sod >> 4
    localparam logic [15:0] MIN_RECIP   = 16'd34952;    // 2^19 / 15, for sod >> 2
    localparam logic [15:0] CYCLE_RECIP = 16'd45933;    // 2^26 / 1461

    localparam logic [9:0]  DAY_SHIFTED   = 10'd675;   // 86400 >> 7
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
    localparam logic [10:0] DAYS_PER_YEAR = 11'd365;

    // Day numbers count from 1968-03-01, so that every leap day ends a year.
    localparam logic [15:0] EPOCH_OFFSET = 16'd671;
    // First day of March 2100 in that count: the missing leap day of 2100 is
    // skipped by adding one from here on.
    localparam logic [15:0] MARCH_2100   = 16'd48212;
    localparam logic [5:0]  QUAD_2096    = 6'd32;
    localparam logic [7:0]  BASE_YEAR    = 8'd68;  // 1968 - 1900

    // Month position in a year that starts in March: January is ten.
    localparam logic [3:0]  MP_JANUARY   = 4'd10;
    localparam logic [8:0]  JAN_FIRST    = 9'd306;
    localparam logic [8:0]  MAR_FIRST    = 9'd59;

    // First day of each month within a year that starts on March 1.
    localparam logic [8:0] MAR_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // Month position (0 is March) of a day within a March-based year.
    function automatic logic [3:0] march_month(input logic [8:0] doy);
        logic [3:0] mp;
        mp = '0;
        for (int k = 1; k < 12; k++) begin
            if (doy >= MAR_START[k]) begin
                mp = 4'(k);
            end
        end
        return mp;
    endfunction

endpackage

>>> src/epoch_seconds_to_utc_date.sv
`timescale 1ns / 1ps
// Top level of the epoch seconds to UTC date converter: six-stage datapath.
// Depends on es2u_pkg and es2u_ctrl.

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into second,
// minute, hour, weekday, years since 1900, day of the year, month and day of the
// month, following the full Gregorian leap-year rule (2100 is a common year).
// The datapath is six register stages deep, and a new timestamp can be taken in
// every cycle unless every stage is full and the output is stalled. The
// stages are set by the chain of constant divisions (seconds into days, the day
// count into four-year cycles, seconds of the day into hours and minutes), each
// done as a reciprocal multiplication in one stage followed by a correcting
// subtraction in the next. When the output is stalled, the stages fill up and
// s_axis_tready falls only once every stage holds a result; s_axis_tready
// depends combinationally on m_axis_tready.
module epoch_seconds_to_utc_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [5:0] second, [11:6] minute, [16:12] hour,
                                       // [19:17] weekday, [27:20] years_since_1900,
                                       // [36:28] day_of_year, [40:37] month_index,
                                       // [45:41] day_of_month, [47:46] zero
);

    es2u_pkg::t_pipe_ctl ctl;

    es2u_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (ctl)
    );

    assign s_axis_tready = ctl.load[0];
    assign m_axis_tvalid = ctl.valid[es2u_pkg::NSTAGE-1];

    // ------------------------------------------------------------------
    // Stage 1: estimate the day count from the seconds divided by 128.
    logic [24:0] r_s1_x, n_s1_x;
    logic [6:0]  r_s1_lo, n_s1_lo;
    logic [15:0] r_s1_q, n_s1_q;
    logic [50:0] prod1;

    always_comb begin
        n_s1_x  = s_axis_tdata[31:7];
        n_s1_lo = s_axis_tdata[6:0];
        prod1   = 51'(s_axis_tdata[31:7]) * 51'(es2u_pkg::DAY_RECIP);
        n_s1_q  = prod1[50:35];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_s1_x  <= n_s1_x;
            r_s1_lo <= n_s1_lo;
            r_s1_q  <= n_s1_q;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: correct the day count and form the seconds of the day.
    logic [15:0] r_s2_days, n_s2_days;
    logic [16:0] r_s2_sod, n_s2_sod;
    logic [25:0] prod2;
    logic [25:0] rem2;
    logic        fix2;
    logic [10:0] rem2_adj;

    always_comb begin
        prod2     = 26'(r_s1_q) * 26'(es2u_pkg::DAY_SHIFTED);
        rem2      = 26'(r_s1_x) - prod2;
        fix2      = rem2[10:0] >= 11'(es2u_pkg::DAY_SHIFTED);
        rem2_adj  = fix2 ? (rem2[10:0] - 11'(es2u_pkg::DAY_SHIFTED)) : rem2[10:0];
        n_s2_days = fix2 ? (r_s1_q + 16'd1) : r_s1_q;
        n_s2_sod  = {rem2_adj[9:0], r_s1_lo};
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[1]) begin
            r_s2_days <= n_s2_days;
            r_s2_sod  <= n_s2_sod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: weekday, and estimates of hour, minute count and cycle.
    logic [16:0] r_s3_sod;
    logic [15:0] r_s3_dv, n_s3_dv;
    logic [2:0]  r_s3_wd, n_s3_wd;
    logic [4:0]  r_s3_h, n_s3_h;
    logic [10:0] r_s3_mt, n_s3_mt;
    logic [5:0]  r_s3_c, n_s3_c;
    logic [15:0] dsh;
    logic [15:0] wsum;
    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [24:0] prodh;
    logic [29:0] prodm;
    logic [31:0] prodc;

    always_comb begin
        // Day number from 1968-03-01, plus one from March 2100 on for the missing leap day.
        dsh     = r_s2_days + es2u_pkg::EPOCH_OFFSET;
        n_s3_dv = dsh + 16'(dsh >= es2u_pkg::MARCH_2100);
        // Day count plus four modulo seven, by summing octal digits (8 = 1 mod 7).
        wsum  = r_s2_days + 16'd4;
        fold1 = 6'(wsum[2:0]) + 6'(wsum[5:3]) + 6'(wsum[8:6]) + 6'(wsum[11:9])
              + 6'(wsum[14:12]) + 6'(wsum[15]);
        fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
        n_s3_wd = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
        // Quotient estimates, each exact or one short.
        prodh   = 25'(r_s2_sod[16:4]) * 25'(es2u_pkg::HOUR_RECIP);
        n_s3_h  = prodh[24:20];
        prodm   = 30'(r_s2_sod[16:2]) * 30'(es2u_pkg::MIN_RECIP);
        n_s3_mt = prodm[29:19];
        prodc   = 32'(n_s3_dv) * 32'(es2u_pkg::CYCLE_RECIP);
        n_s3_c  = prodc[31:26];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[2]) begin
            r_s3_sod <= r_s2_sod;
            r_s3_dv  <= n_s3_dv;
            r_s3_wd  <= n_s3_wd;
            r_s3_h   <= n_s3_h;
            r_s3_mt  <= n_s3_mt;
            r_s3_c   <= n_s3_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the estimates; second and day within the cycle fall out.
    logic [5:0]  r_s4_sec, n_s4_sec;
    logic [4:0]  r_s4_hour, n_s4_hour;
    logic [10:0] r_s4_mt, n_s4_mt;
    logic [5:0]  r_s4_cyc, n_s4_cyc;
    logic [10:0] r_s4_r, n_s4_r;
    logic [2:0]  r_s4_wd;
    logic [16:0] sd;
    logic [16:0] hd;
    logic [15:0] cd;
    logic        fix_s, fix_h, fix_c;
    logic [6:0]  sd_adj;
    logic [11:0] cd_adj;

    always_comb begin
        sd        = r_s3_sod - 17'(r_s3_mt) * 17'(es2u_pkg::SECS_PER_MIN);
        fix_s     = sd[6:0] >= es2u_pkg::SECS_PER_MIN;
        sd_adj    = fix_s ? (sd[6:0] - es2u_pkg::SECS_PER_MIN) : sd[6:0];
        n_s4_sec  = sd_adj[5:0];
        n_s4_mt   = r_s3_mt + 11'(fix_s);

        hd        = r_s3_sod - 17'(r_s3_h) * es2u_pkg::SECS_PER_HOUR;
        fix_h     = hd[12:0] >= 13'(es2u_pkg::SECS_PER_HOUR);
        n_s4_hour = r_s3_h + 5'(fix_h);

        cd        = r_s3_dv - 16'(r_s3_c) * 16'(es2u_pkg::DAYS_PER_QUAD);
        fix_c     = cd[11:0] >= 12'(es2u_pkg::DAYS_PER_QUAD);
        cd_adj    = fix_c ? (cd[11:0] - 12'(es2u_pkg::DAYS_PER_QUAD)) : cd[11:0];
        n_s4_r    = cd_adj[10:0];
        n_s4_cyc  = r_s3_c + 6'(fix_c);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[3]) begin
            r_s4_sec  <= n_s4_sec;
            r_s4_hour <= n_s4_hour;
            r_s4_mt   <= n_s4_mt;
            r_s4_cyc  <= n_s4_cyc;
            r_s4_r    <= n_s4_r;
            r_s4_wd   <= r_s3_wd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: minute, year within the cycle and day within the March year.
    logic [5:0]  r_s5_sec;
    logic [5:0]  r_s5_min, n_s5_min;
    logic [4:0]  r_s5_hour;
    logic [2:0]  r_s5_wd;
    logic [7:0]  r_s5_yr, n_s5_yr;
    logic [8:0]  r_s5_doy, n_s5_doy;
    logic        r_s5_leap, n_s5_leap;
    logic [1:0]  yic;
    logic [10:0] min_full;
    logic [10:0] doy_full;

    always_comb begin
        min_full = r_s4_mt - 11'(r_s4_hour) * 11'(es2u_pkg::SECS_PER_MIN);
        n_s5_min = min_full[5:0];
        // A cycle holds three common years and then the leap year.
        if (r_s4_r >= 11'd1095) begin
            yic = 2'd3;
        end else if (r_s4_r >= 11'd730) begin
            yic = 2'd2;
        end else if (r_s4_r >= es2u_pkg::DAYS_PER_YEAR) begin
            yic = 2'd1;
        end else begin
            yic = 2'd0;
        end
        doy_full  = r_s4_r - 11'(yic) * es2u_pkg::DAYS_PER_YEAR;
        n_s5_doy  = doy_full[8:0];
        n_s5_yr   = es2u_pkg::BASE_YEAR + {r_s4_cyc, 2'b00} + 8'(yic);
        // The year 2100 is a common year, so its days from March on take no leap day.
        n_s5_leap = (yic == 2'd0) && (r_s4_cyc != es2u_pkg::QUAD_2096 + 6'd1);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[4]) begin
            r_s5_sec  <= r_s4_sec;
            r_s5_min  <= n_s5_min;
            r_s5_hour <= r_s4_hour;
            r_s5_wd   <= r_s4_wd;
            r_s5_yr   <= n_s5_yr;
            r_s5_doy  <= n_s5_doy;
            r_s5_leap <= n_s5_leap;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: month and day of the month, back to a January-based year.
    logic [5:0] r_s6_sec, r_s6_min;
    logic [4:0] r_s6_hour;
    logic [2:0] r_s6_wd;
    logic [7:0] r_s6_years, n_s6_years;
    logic [8:0] r_s6_yday, n_s6_yday;
    logic [3:0] r_s6_mon, n_s6_mon;
    logic [4:0] r_s6_mday, n_s6_mday;
    logic [3:0] mp;
    logic       next_year;
    logic [8:0] mday_full;

    always_comb begin
        mp         = es2u_pkg::march_month(r_s5_doy);
        next_year  = mp >= es2u_pkg::MP_JANUARY;
        mday_full  = r_s5_doy - es2u_pkg::MAR_START[mp] + 9'd1;
        n_s6_mday  = mday_full[4:0];
        n_s6_mon   = next_year ? (mp - es2u_pkg::MP_JANUARY) : (mp + 4'd2);
        n_s6_years = r_s5_yr + 8'(next_year);
        n_s6_yday  = next_year ? (r_s5_doy - es2u_pkg::JAN_FIRST)
                               : (r_s5_doy + es2u_pkg::MAR_FIRST + 9'(r_s5_leap));
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[5]) begin
            r_s6_sec   <= r_s5_sec;
            r_s6_min   <= r_s5_min;
            r_s6_hour  <= r_s5_hour;
            r_s6_wd    <= r_s5_wd;
            r_s6_years <= n_s6_years;
            r_s6_yday  <= n_s6_yday;
            r_s6_mon   <= n_s6_mon;
            r_s6_mday  <= n_s6_mday;
        end
    end

    assign m_axis_tdata = {2'b00, r_s6_mday, r_s6_mon, r_s6_yday, r_s6_years,
                           r_s6_wd, r_s6_hour, r_s6_min, r_s6_sec};

endmodule

>>> src/es2u_ctrl.sv
`timescale 1ns / 1ps
// Valid bits and stage hold logic of the converter pipeline.
// Depends on es2u_pkg for the stage count and the control struct.
module es2u_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output es2u_pkg::t_pipe_ctl o_ctl
);

    logic [es2u_pkg::NSTAGE-1:0] r_vld;
    logic [es2u_pkg::NSTAGE-1:0] n_vld;
    logic [es2u_pkg::NSTAGE-1:0] load;

    // A stage may take new data when it is empty or when its contents move on.
    always_comb begin
        load[es2u_pkg::NSTAGE-1] = ~r_vld[es2u_pkg::NSTAGE-1] | i_out_ready;
        for (int k = es2u_pkg::NSTAGE - 2; k >= 0; k--) begin
            load[k] = ~r_vld[k] | load[k+1];
        end
    end

    // Valid bits follow the data; a stage that holds keeps its bit.
    always_comb begin
        n_vld = r_vld;
        if (load[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < es2u_pkg::NSTAGE; k++) begin
            if (load[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.load  = load;
    assign o_ctl.valid = r_vld;

endmodule
